FILE: rtl/arqt_pkg.sv
// Package for the aged request queue table.
// Types, request and status codes shared by the cell, the control and the top level.
package arqt_pkg;

    localparam int DEPTH    = 16;
    localparam int TAG_BITS = 16;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_GET    = 3'd1;
    localparam logic [2:0] REQ_FIND   = 3'd2;
    localparam logic [2:0] REQ_UPDATE = 3'd3;
    localparam logic [2:0] REQ_REMOVE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_MATCH = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic CFG_MAX_ENTRIES = 1'b0;
    localparam logic CFG_DROP_OLDEST = 1'b1;

    // One stored entry
    typedef struct packed {
        logic                taken;
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         ip;
        logic [47:0]         mac;
        logic [15:0]         net;
        logic [31:0]         gw;
        logic [31:0]         tstamp;
    } t_entry;

    // Key broadcast to every cell for the compare cycle
    typedef struct packed {
        logic [2:0]          req;
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         ip;
        logic [47:0]         mac;
        logic [15:0]         net;
        logic [31:0]         gw;
        logic [31:0]         now;
        logic [31:0]         age;
    } t_key;

    // Command from the control to every cell
    typedef struct packed {
        logic                shift;   // cells at or above sel_idx take neighbor's entry
        logic                append;  // cell at sel_idx loads the new entry
        logic                mark;    // cell at sel_idx sets taken
        logic                set_ip;  // cell at sel_idx loads new ip
        logic [IDX_BITS-1:0] sel_idx;
    } t_cmd;

endpackage

FILE: rtl/aged_request_queue_table_top.sv
// Top level of the aged request queue table: cell chain and request control.
// Depends on arqt_pkg and arqt_cell.
//
//  channel | signals                         | moves
//  --------+---------------------------------+------------------------
//  request | i_req_valid / o_req_ready       | one request per transfer
//  result  | o_res_valid / i_res_ready       | one result per request
//  config  | i_cfg_valid / o_cfg_ready       | register index and data
//
// A request passes from transfer to result through compare, priority
// pick over the cells, then collapse or append; a full add that drops
// the oldest entry first repeats the action step. One request is in work
// at a time; the next is taken once the result register is free. Config
// writes are taken only while no request is in work. Reset clears valid
// bits and counts; entry payload is not cleared. A stalled result holds.
module aged_request_queue_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_msg_handle,
    input  logic [31:0] i_client_ip,
    input  logic [47:0] i_client_mac,
    input  logic [15:0] i_network_id,
    input  logic [31:0] i_gateway_ip,
    input  logic [31:0] i_now_us,
    input  logic [31:0] i_age_us,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_found_handle,
    output logic        o_dropped,
    output logic [15:0] o_dropped_handle,
    output logic [4:0]  o_entry_count,
    output logic [4:0]  o_pending_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    localparam int D  = arqt_pkg::DEPTH;
    localparam int IB = arqt_pkg::IDX_BITS;
    localparam int CB = arqt_pkg::CNT_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_ACT  = 2'd3;

    logic [1:0]          r_state, n_state;
    arqt_pkg::t_key      r_key;
    arqt_pkg::t_cmd      w_cmd;
    logic [D-1:0]        r_valid, w_hit, r_hit;
    logic                r_found, r_did_drop;
    logic [IB-1:0]       r_idx;
    logic [IB-1:0]       w_pick;
    logic [CB-1:0]       r_used, r_untaken;
    logic [4:0]          r_max;
    logic                r_drop_oldest;
    logic                r_res_valid;
    logic [1:0]          r_status;
    logic [15:0]         r_found_handle, r_dropped_handle;
    arqt_pkg::t_entry    w_ent [D];
    arqt_pkg::t_entry    w_up  [D];
    logic [CB-1:0]       w_limit;
    logic                w_full;

    // Cell chain; each cell takes its upper neighbor's entry on collapse
    for (genvar g = 0; g < D; g++) begin : g_cell
        if (g == D - 1) begin : g_last
            assign w_up[g] = w_ent[g];
        end else begin : g_mid
            assign w_up[g] = w_ent[g+1];
        end
        arqt_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IB'(g)),
            .i_valid (r_valid[g]),
            .i_key   (r_key),
            .i_cmd   (w_cmd),
            .i_upper (w_up[g]),
            .o_entry (w_ent[g]),
            .o_hit   (w_hit[g])
        );
    end

    // Effective limit
    always_comb begin
        if (r_max == 5'd0)           w_limit = CB'(1);
        else if (32'(r_max) > D)     w_limit = CB'(D);
        else                         w_limit = CB'(r_max);
        w_full = r_used >= w_limit;
    end

    // Lowest hitting cell wins
    always_comb begin
        w_pick = '0;
        for (int k = D - 1; k >= 0; k--) begin
            if (r_hit[k]) w_pick = IB'(k);
        end
    end

    assign o_req_ready = (r_state == S_IDLE) && !r_res_valid;
    assign o_cfg_ready = (r_state == S_IDLE);

    // Cell command for the action cycle
    always_comb begin
        w_cmd = '0;
        w_cmd.sel_idx = r_idx;
        if (r_state == S_ACT) begin
            case (r_key.req)
                arqt_pkg::REQ_ADD: begin
                    if (w_full && r_drop_oldest && !r_did_drop && r_used != '0) begin
                        w_cmd.shift   = 1'b1;
                        w_cmd.sel_idx = '0;
                    end else if ((!w_full || r_did_drop) && 32'(r_used) < D) begin
                        w_cmd.append  = 1'b1;
                        w_cmd.sel_idx = r_used[IB-1:0];
                    end
                end
                arqt_pkg::REQ_GET:    w_cmd.mark   = r_found;
                arqt_pkg::REQ_UPDATE: w_cmd.set_ip = r_found;
                arqt_pkg::REQ_REMOVE: w_cmd.shift  = r_found && r_used != '0;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req_valid && o_req_ready) n_state = S_CMP;
            S_CMP:  n_state = S_PICK;
            S_PICK: n_state = S_ACT;
            S_ACT:  if (!w_cmd.shift || r_key.req != arqt_pkg::REQ_ADD) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control, counts and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_used        <= '0;
            r_untaken     <= '0;
            r_max         <= 5'd16;
            r_drop_oldest <= 1'b0;
            r_res_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == arqt_pkg::CFG_MAX_ENTRIES) r_max <= i_cfg_data;
                else                                         r_drop_oldest <= i_cfg_data[0];
            end
            if (r_res_valid && i_res_ready) r_res_valid <= 1'b0;
            if (i_req_valid && o_req_ready) begin
                r_key.req <= i_req_type;
                r_key.tag <= i_msg_handle[arqt_pkg::TAG_BITS-1:0];
                r_key.ip  <= i_client_ip;
                r_key.mac <= i_client_mac;
                r_key.net <= i_network_id;
                r_key.gw  <= i_gateway_ip;
                r_key.now <= i_now_us;
                r_key.age <= i_age_us;
                r_did_drop       <= 1'b0;
                r_dropped_handle <= '0;
            end
            if (r_state == S_CMP) r_hit <= w_hit;
            if (r_state == S_PICK) begin
                r_found <= |r_hit;
                r_idx   <= w_pick;
            end
            if (r_state == S_ACT) begin
                if (w_cmd.shift) begin
                    if (!w_ent[w_cmd.sel_idx].taken && r_untaken != '0)
                        r_untaken <= r_untaken - CB'(1);
                    r_used  <= r_used - CB'(1);
                    r_valid <= r_valid >> 1;
                    if (r_key.req == arqt_pkg::REQ_ADD) begin
                        r_did_drop       <= 1'b1;
                        r_dropped_handle <= 16'(w_ent[0].tag);
                    end
                end
                if (w_cmd.append) begin
                    r_used  <= r_used + CB'(1);
                    r_untaken <= r_untaken + CB'(1);
                    r_valid[r_used[IB-1:0]] <= 1'b1;
                end
                if (w_cmd.mark && r_untaken != '0) r_untaken <= r_untaken - CB'(1);
                if (n_state == S_IDLE) begin
                    r_res_valid    <= 1'b1;
                    case (r_key.req)
                        arqt_pkg::REQ_ADD: begin
                            r_status <= (w_full && !r_drop_oldest) ? arqt_pkg::ST_FULL
                                                                   : arqt_pkg::ST_OK;
                            r_found_handle <= '0;
                        end
                        arqt_pkg::REQ_GET, arqt_pkg::REQ_FIND, arqt_pkg::REQ_UPDATE: begin
                            r_status <= r_found ? arqt_pkg::ST_OK : arqt_pkg::ST_NO_MATCH;
                            r_found_handle <= r_found ? 16'(w_ent[r_idx].tag) : 16'd0;
                        end
                        arqt_pkg::REQ_REMOVE: begin
                            if (r_used == '0) r_status <= arqt_pkg::ST_EMPTY;
                            else r_status <= r_found ? arqt_pkg::ST_OK
                                                     : arqt_pkg::ST_NO_MATCH;
                            r_found_handle <= (r_found && r_used != '0) ? 16'(r_key.tag)
                                                                        : 16'd0;
                        end
                        default: begin
                            r_status       <= arqt_pkg::ST_NO_MATCH;
                            r_found_handle <= '0;
                        end
                    endcase
                end
            end
        end
    end

    assign o_res_valid      = r_res_valid;
    assign o_status         = r_status;
    assign o_found_handle   = r_found_handle;
    assign o_dropped        = r_did_drop;
    assign o_dropped_handle = r_dropped_handle;
    assign o_entry_count    = 5'(r_used);
    assign o_pending_count  = 5'(r_untaken);

endmodule

FILE: rtl/arqt_cell.sv
// One cell of the table: holds one entry, compares it with the key.
// Depends on arqt_pkg.
module arqt_cell (
    input  logic               i_clk,
    input  logic [arqt_pkg::IDX_BITS-1:0] i_idx,
    input  logic               i_valid,
    input  arqt_pkg::t_key     i_key,
    input  arqt_pkg::t_cmd     i_cmd,
    input  arqt_pkg::t_entry   i_upper,
    output arqt_pkg::t_entry   o_entry,
    output logic               o_hit
);

    arqt_pkg::t_entry r_entry;
    logic [31:0]      w_age;

    assign o_entry = r_entry;
    assign w_age   = i_key.now - r_entry.tstamp;

    // Match per request type, registered by the control
    always_comb begin
        case (i_key.req)
            arqt_pkg::REQ_GET:    o_hit = i_valid && !r_entry.taken &&
                                          (i_key.age == 32'd0 || w_age >= i_key.age);
            arqt_pkg::REQ_FIND:   o_hit = i_valid && r_entry.ip == i_key.ip;
            arqt_pkg::REQ_UPDATE: o_hit = i_valid && r_entry.mac == i_key.mac &&
                                          r_entry.net == i_key.net && r_entry.gw == i_key.gw;
            arqt_pkg::REQ_REMOVE: o_hit = i_valid && r_entry.tag == i_key.tag;
            default:              o_hit = 1'b0;
        endcase
    end

    // Shift from neighbor, append, or field updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift && i_idx >= i_cmd.sel_idx) begin
            r_entry <= i_upper;
        end else if (i_idx == i_cmd.sel_idx) begin
            if (i_cmd.append) begin
                r_entry.taken  <= 1'b0;
                r_entry.tag    <= i_key.tag;
                r_entry.ip     <= i_key.ip;
                r_entry.mac    <= i_key.mac;
                r_entry.net    <= i_key.net;
                r_entry.gw     <= i_key.gw;
                r_entry.tstamp <= i_key.now;
            end
            if (i_cmd.mark) begin
                r_entry.taken <= 1'b1;
            end
            if (i_cmd.set_ip) begin
                r_entry.ip <= i_key.ip;
            end
        end
    end

endmodule

FILE: rtl/arqt_checker.sv
// Port-level checks for the aged request queue table.
// Depends on arqt_pkg and aged_request_queue_table_top (bound to it below).
module arqt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_req_ready,
    input logic        o_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  o_status,
    input logic        o_dropped,
    input logic [4:0]  o_entry_count,
    input logic [4:0]  o_pending_count
);

    // A stalled result holds its status
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_status))
        else $error("result changed while stalled");

    // Pending never exceeds entries while a result is valid
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_pending_count <= o_entry_count)
        else $error("pending above entry count");

    // No new request while a result waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !o_req_ready)
        else $error("ready with result pending");

    // A drop comes only with an ok status
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_dropped |-> o_status == arqt_pkg::ST_OK)
        else $error("drop with bad status");

endmodule

bind aged_request_queue_table_top arqt_checker u_arqt_checker (.*);
